/* rtl/core/bandpass_pole_transform_assert.svh */
// Assertion macros for the checker file of this block.
// Both macros expect clk and rst_n in scope.
`ifndef BANDPASS_POLE_TRANSFORM_ASSERT_SVH
`define BANDPASS_POLE_TRANSFORM_ASSERT_SVH

// Same-cycle implication.
`define BPT_ASSERT_NOW(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("bandpass_pole_transform assertion failed");

// Next-cycle implication.
`define BPT_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("bandpass_pole_transform assertion failed");

`endif

/* rtl/core/bpt_pkg.sv */
package bpt_pkg;

  localparam int MAX_ORDER = 16;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_LOW_EDGE   = 2'd0;
  localparam logic [1:0] REG_HIGH_EDGE  = 2'd1;
  localparam logic [1:0] REG_PROTO_GAIN = 2'd2;
  localparam logic [1:0] REG_ORDER      = 2'd3;

  localparam logic [30:0] LOW_EDGE_RST   = 31'd65536;
  localparam logic [30:0] HIGH_EDGE_RST  = 31'd131072;
  localparam logic signed [31:0] PROTO_GAIN_RST = 32'sd65536;
  localparam logic [4:0] ORDER_RST      = 5'd1;

  // Datapath micro steps, one per cycle
  localparam logic [3:0] ST_P_RE    = 4'd0;
  localparam logic [3:0] ST_P_IM    = 4'd1;
  localparam logic [3:0] ST_SQ_RE   = 4'd2;
  localparam logic [3:0] ST_SQ_IM   = 4'd3;
  localparam logic [3:0] ST_CROSS   = 4'd4;
  localparam logic [3:0] ST_EDGES   = 4'd5;
  localparam logic [3:0] ST_GAIN    = 4'd6;
  localparam logic [3:0] ST_RAD     = 4'd7;
  localparam logic [3:0] ST_MAG_RE  = 4'd8;
  localparam logic [3:0] ST_MAG_IM  = 4'd9;
  localparam logic [3:0] ST_MAG_SUM = 4'd10;

  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

  typedef enum logic [1:0] {
    SQ_MAG,
    SQ_RE,
    SQ_IM
  } sq_sel_t;

  typedef struct packed {
    logic [30:0]        low_edge;
    logic [30:0]        high_edge;
    logic signed [31:0] proto_gain;
    logic [4:0]         order;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       step_en;
    logic [3:0] step;
    logic       sq_start;
    sq_sel_t    sq_sel;
    logic       fin;
  } cmd_t;

  typedef struct packed {
    logic sq_done;
  } status_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               hit;
  } sat_t;

  // Round to nearest, ties toward +inf, then arithmetic shift
  function automatic logic signed [65:0] rnd(input logic signed [65:0] v,
                                             input logic [4:0] s);
    logic signed [65:0] half;
    half = 66'sd1 <<< (s - 5'd1);
    return (v + half) >>> s;
  endfunction

  // Clamp to signed 32 bits and flag the clamp
  function automatic sat_t sat32(input logic signed [65:0] v);
    sat_t r;
    if (v > SAT_MAX) begin
      r.val = 32'sh7FFFFFFF;
      r.hit = 1'b1;
    end else if (v < SAT_MIN) begin
      r.val = 32'sh80000000;
      r.hit = 1'b1;
    end else begin
      r.val = v[31:0];
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage

/* rtl/core/bpt_isqrt.sv */
module bpt_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] din,
  output logic [31:0] root,
  output logic        done
);

  logic [63:0] v_r, v_nxt;
  logic [63:0] res_r, res_nxt;
  logic [63:0] bit_r;
  logic        busy_r;
  logic        done_r;
  logic [63:0] trial;

  // One result bit per cycle
  always_comb begin
    trial   = res_r + bit_r;
    v_nxt   = v_r;
    res_nxt = res_r >> 1;
    if (v_r >= trial) begin
      v_nxt   = v_r - trial;
      res_nxt = (res_r >> 1) + bit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r == 64'd1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= din;
      res_r <= '0;
      bit_r <= 64'd1 << 62;
    end else if (busy_r) begin
      v_r   <= v_nxt;
      res_r <= res_nxt;
      bit_r <= bit_r >> 2;
    end
  end

  assign root = res_r[31:0];
  assign done = done_r;

endmodule

/* rtl/core/bpt_datapath.sv */
module bpt_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  bpt_pkg::cfg_t       cfg,
  input  bpt_pkg::cmd_t       cmd,
  output bpt_pkg::status_t    status,
  input  logic signed [31:0]  in_pole_re,
  input  logic signed [31:0]  in_pole_im,
  output logic signed [31:0]  out_upper_re,
  output logic signed [31:0]  out_upper_im,
  output logic signed [31:0]  out_lower_re,
  output logic signed [31:0]  out_lower_im,
  output logic [3:0]          out_upper_slot,
  output logic [4:0]          out_lower_slot,
  output logic signed [31:0]  out_gain_out,
  output logic                out_saturated,
  output logic                out_last_pole
);

  logic signed [31:0] pre_r, pim_r, bre_r, bim_r, rre_r, rim_r, g_r;
  logic signed [63:0] prod_r;
  logic signed [64:0] acc_r;
  logic [63:0]        sq_r;
  logic [31:0]        m_r, tre_r;
  logic signed [31:0] tim_r;
  logic               sat_r;
  logic [3:0]         cnt_r;
  logic signed [31:0] run_gain_r;

  logic signed [31:0] d, fh, fl, g0, op_a, op_b;
  logic [4:0]         eff;
  logic               last;
  logic signed [65:0] prod_x;
  logic signed [33:0] h_re_sum, h_im_sum;
  logic [63:0]        sq_din;
  logic [31:0]        root;
  logic               sq_done;
  bpt_pkg::sat_t      s_a, s_b, s_ur, s_ui, s_lr, s_li;

  assign fh     = {1'b0, cfg.high_edge};
  assign fl     = {1'b0, cfg.low_edge};
  assign d      = fh - fl;
  assign g0     = (cnt_r == 4'd0) ? cfg.proto_gain : run_gain_r;
  assign prod_x = {{2{prod_r[63]}}, prod_r};

  // Clamp order to 1..MAX_ORDER
  always_comb begin
    eff = cfg.order;
    if (cfg.order == 5'd0) eff = 5'd1;
    else if (cfg.order > 5'(bpt_pkg::MAX_ORDER)) eff = 5'(bpt_pkg::MAX_ORDER);
  end
  assign last = ({1'b0, cnt_r} + 5'd1) >= eff;

  // Select multiplier operands per step
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (cmd.step)
      bpt_pkg::ST_P_RE:   begin op_a = pre_r;  op_b = d;     end
      bpt_pkg::ST_P_IM:   begin op_a = pim_r;  op_b = d;     end
      bpt_pkg::ST_SQ_RE:  begin op_a = bre_r;  op_b = bre_r; end
      bpt_pkg::ST_SQ_IM:  begin op_a = bim_r;  op_b = bim_r; end
      bpt_pkg::ST_CROSS:  begin op_a = bre_r;  op_b = bim_r; end
      bpt_pkg::ST_EDGES:  begin op_a = fh;     op_b = fl;    end
      bpt_pkg::ST_GAIN:   begin op_a = g0;     op_b = d;     end
      bpt_pkg::ST_MAG_RE: begin op_a = rre_r;  op_b = rre_r; end
      bpt_pkg::ST_MAG_IM: begin op_a = rim_r;  op_b = rim_r; end
      default:            begin op_a = '0;     op_b = '0;    end
    endcase
  end

  // Rounding and clamping of the consumed product
  always_comb begin
    s_a = bpt_pkg::sat32(bpt_pkg::rnd(prod_x, 5'd17));
    s_b = bpt_pkg::sat32(bpt_pkg::rnd({acc_r[64], acc_r}, 5'd16));
    unique case (cmd.step)
      bpt_pkg::ST_EDGES: s_a = bpt_pkg::sat32(bpt_pkg::rnd(prod_x, 5'd15));
      bpt_pkg::ST_RAD:   s_a = bpt_pkg::sat32(bpt_pkg::rnd(prod_x, 5'd16));
      default:           s_a = bpt_pkg::sat32(bpt_pkg::rnd(prod_x, 5'd17));
    endcase
  end

  // Square root operand: |r|^2, then (m +/- r_re)/2 scaled by 2^16
  assign h_re_sum = $signed({2'b00, m_r}) + {{2{rre_r[31]}}, rre_r};
  assign h_im_sum = $signed({2'b00, m_r}) - {{2{rre_r[31]}}, rre_r};
  always_comb begin
    unique case (cmd.sq_sel)
      bpt_pkg::SQ_MAG: sq_din = sq_r;
      bpt_pkg::SQ_RE:  sq_din = {16'd0, h_re_sum[32:1], 16'd0};
      bpt_pkg::SQ_IM:  sq_din = {16'd0, h_im_sum[32:1], 16'd0};
      default:         sq_din = sq_r;
    endcase
  end

  bpt_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sq_start),
    .din   (sq_din),
    .root  (root),
    .done  (sq_done)
  );

  assign status.sq_done = sq_done;

  // Final sums
  always_comb begin
    s_ur = bpt_pkg::sat32(66'(bre_r) + $signed({34'd0, tre_r}));
    s_lr = bpt_pkg::sat32(66'(bre_r) - $signed({34'd0, tre_r}));
    s_ui = bpt_pkg::sat32(66'(bim_r) + 66'(tim_r));
    s_li = bpt_pkg::sat32(66'(bim_r) - 66'(tim_r));
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pre_r <= in_pole_re;
      pim_r <= in_pole_im;
      sat_r <= 1'b0;
    end
    if (cmd.step_en) begin
      prod_r <= op_a * op_b;
      unique case (cmd.step)
        bpt_pkg::ST_P_IM: begin
          bre_r <= s_a.val;
          sat_r <= sat_r | s_a.hit;
        end
        bpt_pkg::ST_SQ_RE: begin
          bim_r <= s_a.val;
          sat_r <= sat_r | s_a.hit;
        end
        bpt_pkg::ST_SQ_IM: acc_r <= 65'(prod_r);
        bpt_pkg::ST_CROSS: acc_r <= acc_r - 65'(prod_r);
        bpt_pkg::ST_EDGES: begin
          rim_r <= s_a.val;
          sat_r <= sat_r | s_a.hit;
        end
        bpt_pkg::ST_GAIN:  acc_r <= acc_r - 65'(prod_r);
        bpt_pkg::ST_RAD: begin
          g_r   <= s_a.val;
          rre_r <= s_b.val;
          sat_r <= sat_r | s_a.hit | s_b.hit;
        end
        bpt_pkg::ST_MAG_IM:  sq_r <= prod_r;
        bpt_pkg::ST_MAG_SUM: sq_r <= sq_r + prod_r;
        default: ;
      endcase
    end
    if (sq_done) begin
      unique case (cmd.sq_sel)
        bpt_pkg::SQ_MAG: m_r <= root;
        bpt_pkg::SQ_RE:  tre_r <= root;
        bpt_pkg::SQ_IM:  tim_r <= rim_r[31] ? -$signed(root) : $signed(root);
        default: ;
      endcase
    end
    if (cmd.fin) begin
      out_upper_re   <= s_ur.val;
      out_upper_im   <= s_ui.val;
      out_lower_re   <= s_lr.val;
      out_lower_im   <= s_li.val;
      out_upper_slot <= cnt_r;
      out_lower_slot <= {1'b0, cnt_r} + eff;
      out_gain_out   <= g_r;
      out_saturated  <= sat_r | s_ur.hit | s_ui.hit | s_lr.hit | s_li.hit;
      out_last_pole  <= last;
    end
  end

  // Pole counter and running gain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      run_gain_r <= bpt_pkg::PROTO_GAIN_RST;
    end else if (cmd.fin) begin
      cnt_r      <= last ? 4'd0 : cnt_r + 4'd1;
      run_gain_r <= g_r;
    end
  end

endmodule

/* rtl/core/bpt_ctrl.sv */
module bpt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  bpt_pkg::status_t status,
  output bpt_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SQ,
    S_SQ_WAIT,
    S_FIN
  } state_t;

  state_t           state_r;
  logic [3:0]       step_r;
  bpt_pkg::sq_sel_t sel_r;
  logic             out_valid_r;

  // Decode commands from state
  always_comb begin
    cmd.load     = (state_r == S_IDLE) && in_valid;
    cmd.step_en  = (state_r == S_MUL);
    cmd.step     = step_r;
    cmd.sq_start = (state_r == S_SQ);
    cmd.sq_sel   = sel_r;
    cmd.fin      = (state_r == S_FIN) && (!out_valid_r || !out_stall);
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      sel_r       <= bpt_pkg::SQ_MAG;
      out_valid_r <= 1'b0;
    end else begin
      // Raise the result on finish, drop it once taken
      if (cmd.fin) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_MUL;
            step_r  <= bpt_pkg::ST_P_RE;
          end
        end
        S_MUL: begin
          if (step_r == bpt_pkg::ST_MAG_SUM) begin
            state_r <= S_SQ;
            sel_r   <= bpt_pkg::SQ_MAG;
          end else begin
            step_r <= step_r + 4'd1;
          end
        end
        S_SQ: state_r <= S_SQ_WAIT;
        S_SQ_WAIT: begin
          if (status.sq_done) begin
            unique case (sel_r)
              bpt_pkg::SQ_MAG: begin
                sel_r   <= bpt_pkg::SQ_RE;
                state_r <= S_SQ;
              end
              bpt_pkg::SQ_RE: begin
                sel_r   <= bpt_pkg::SQ_IM;
                state_r <= S_SQ;
              end
              default: state_r <= S_FIN;
            endcase
          end
        end
        S_FIN: begin
          // Hold until the output register is free
          if (cmd.fin) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/bandpass_pole_transform.sv */
// Lowpass-to-bandpass pole mapper, signed Q16.16.
// Input channel: one prototype pole per request (in_pole_re, in_pole_im),
// taken when in_valid is high and in_stall is low.
// Output channel: one request per pole with both bandpass poles, their list
// slots, the running gain, a saturation flag and a last-pole flag, taken when
// out_valid is high and out_stall is low.
// APB port: low_edge 0x0, high_edge 0x4, proto_gain 0x8, order 0xC;
// pready is always high, writes land at the access cycle.
// One pole is in work at a time: a new pole is taken only once the last one
// has passed its final step. The time per pole is set by the shared 32x32
// multiplier (11 steps) and the one-bit-per-cycle square root unit, which
// runs three times per pole.
// A finished result waits in the output register; while the receiver stalls
// the next pole is still accepted and computed, and it holds in its final
// step until the output register is free.
// Reset: registers return to Fl=1.0, Fh=2.0, gain 1.0, order 1; the pole
// counter clears, so the next pole starts a design.
module bandpass_pole_transform (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_pole_re,
  input  logic signed [31:0] in_pole_im,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_upper_re,
  output logic signed [31:0] out_upper_im,
  output logic signed [31:0] out_lower_re,
  output logic signed [31:0] out_lower_im,
  output logic [3:0]         out_upper_slot,
  output logic [4:0]         out_lower_slot,
  output logic signed [31:0] out_gain_out,
  output logic               out_saturated,
  output logic               out_last_pole,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  bpt_pkg::cfg_t    cfg_r;
  bpt_pkg::cmd_t    cmd;
  bpt_pkg::status_t status;

  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_edge   <= bpt_pkg::LOW_EDGE_RST;
      cfg_r.high_edge  <= bpt_pkg::HIGH_EDGE_RST;
      cfg_r.proto_gain <= bpt_pkg::PROTO_GAIN_RST;
      cfg_r.order      <= bpt_pkg::ORDER_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        bpt_pkg::REG_LOW_EDGE:   cfg_r.low_edge   <= pwdata[30:0];
        bpt_pkg::REG_HIGH_EDGE:  cfg_r.high_edge  <= pwdata[30:0];
        bpt_pkg::REG_PROTO_GAIN: cfg_r.proto_gain <= pwdata;
        bpt_pkg::REG_ORDER:      cfg_r.order      <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (paddr[3:2])
      bpt_pkg::REG_LOW_EDGE:   prdata = {1'b0, cfg_r.low_edge};
      bpt_pkg::REG_HIGH_EDGE:  prdata = {1'b0, cfg_r.high_edge};
      bpt_pkg::REG_PROTO_GAIN: prdata = cfg_r.proto_gain;
      bpt_pkg::REG_ORDER:      prdata = {27'd0, cfg_r.order};
      default:                 prdata = '0;
    endcase
  end

  bpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  bpt_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .cmd            (cmd),
    .status         (status),
    .in_pole_re     (in_pole_re),
    .in_pole_im     (in_pole_im),
    .out_upper_re   (out_upper_re),
    .out_upper_im   (out_upper_im),
    .out_lower_re   (out_lower_re),
    .out_lower_im   (out_lower_im),
    .out_upper_slot (out_upper_slot),
    .out_lower_slot (out_lower_slot),
    .out_gain_out   (out_gain_out),
    .out_saturated  (out_saturated),
    .out_last_pole  (out_last_pole)
  );

endmodule

/* rtl/core/bpt_checker.sv */
`include "bandpass_pole_transform_assert.svh"

module bpt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] out_upper_slot,
  input logic [4:0] out_lower_slot
);

  // Hold a stalled result
  `BPT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // Busy right after a request is taken
  `BPT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // The lower pole always sits past the upper one
  `BPT_ASSERT_NOW(a_slot_order, out_valid, out_lower_slot > {1'b0, out_upper_slot})

endmodule

bind bandpass_pole_transform bpt_checker u_bpt_checker (.*);

/* tb/tb_bandpass_pole_transform.sv */
`timescale 1ns / 1ps

module tb_bandpass_pole_transform;

  // One output request of the block
  typedef struct packed {
    logic signed [31:0] upper_re;
    logic signed [31:0] upper_im;
    logic signed [31:0] lower_re;
    logic signed [31:0] lower_im;
    logic [3:0]         upper_slot;
    logic [4:0]         lower_slot;
    logic signed [31:0] gain;
    logic               saturated;
    logic               last_pole;
  } pole_pair_t;

  // Pole pair predictor and store of pending pole pairs
  class pole_pair_board;
    logic [30:0]        fl;
    logic [30:0]        fh;
    logic signed [31:0] gain0;
    logic [4:0]         ord;
    logic [3:0]         pole_idx;
    longint             run_gain;
    bit                 clamp_hit;
    pole_pair_t         pending[$];
    int                 errors;
    int                 n_checked;
    int                 n_sat;
    int                 n_last;

    function new();
      fl = bpt_pkg::LOW_EDGE_RST;
      fh = bpt_pkg::HIGH_EDGE_RST;
      gain0 = bpt_pkg::PROTO_GAIN_RST;
      ord = bpt_pkg::ORDER_RST;
      pole_idx = 0;
      run_gain = longint'(bpt_pkg::PROTO_GAIN_RST);
      errors = 0;
      n_checked = 0;
      n_sat = 0;
      n_last = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        bpt_pkg::REG_LOW_EDGE:   fl = val[30:0];
        bpt_pkg::REG_HIGH_EDGE:  fh = val[30:0];
        bpt_pkg::REG_PROTO_GAIN: gain0 = val;
        bpt_pkg::REG_ORDER:      ord = val[4:0];
        default: ;
      endcase
    endfunction

    function longint round_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) begin
        clamp_hit = 1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        clamp_hit = 1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function longint unsigned square_mag(longint x);
      longint unsigned a;
      a = (x < 0) ? longint'(-x) : x;
      return a * a;
    endfunction

    // Map one prototype pole and queue the expected pole pair
    function void note_pole(logic signed [31:0] p_re, logic signed [31:0] p_im);
      pole_pair_t e;
      int eff;
      longint d, fhfl, bre, bim, rre, rim, m, h, tre, tim, g;
      bit last;
      eff = (ord == 0) ? 1 : (ord > bpt_pkg::MAX_ORDER) ? bpt_pkg::MAX_ORDER : ord;
      clamp_hit = 0;
      d = longint'(fh) - longint'(fl);
      fhfl = longint'(fh) * longint'(fl);
      bre = clamp32(round_shift(longint'(p_re) * d, 17));
      bim = clamp32(round_shift(longint'(p_im) * d, 17));
      rre = clamp32(round_shift(bre * bre - bim * bim - fhfl, 16));
      rim = clamp32(round_shift(bre * bim, 15));
      m = int_sqrt(square_mag(rre) + square_mag(rim));
      h = (m + rre) >>> 1;
      tre = int_sqrt(longint'(h) << 16);
      h = (m - rre) >>> 1;
      tim = int_sqrt(longint'(h) << 16);
      if (rim < 0) tim = -tim;
      if (pole_idx == 0) run_gain = longint'(gain0);
      g = clamp32(round_shift(run_gain * d, 16));
      run_gain = g;
      last = (int'(pole_idx) + 1 >= eff);
      e.upper_re = 32'(clamp32(bre + tre));
      e.upper_im = 32'(clamp32(bim + tim));
      e.lower_re = 32'(clamp32(bre - tre));
      e.lower_im = 32'(clamp32(bim - tim));
      e.upper_slot = pole_idx;
      e.lower_slot = 5'(int'(pole_idx) + eff);
      e.gain = 32'(g);
      e.saturated = clamp_hit;
      e.last_pole = last;
      pending.push_back(e);
      pole_idx = last ? 4'd0 : pole_idx + 4'd1;
    endfunction

    function void field_cmp(string name, longint e, longint a);
      if (e != a) begin
        $display("%0t: mismatch %s expected %0d actual %0d", $time, name, e, a);
        errors++;
      end
    endfunction

    // Compare one accepted pole pair with the oldest expectation
    function void check_pair(pole_pair_t a);
      pole_pair_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected pole pair, expected none actual %h", $time, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      field_cmp("upper_re", e.upper_re, a.upper_re);
      field_cmp("upper_im", e.upper_im, a.upper_im);
      field_cmp("lower_re", e.lower_re, a.lower_re);
      field_cmp("lower_im", e.lower_im, a.lower_im);
      field_cmp("upper_slot", e.upper_slot, a.upper_slot);
      field_cmp("lower_slot", e.lower_slot, a.lower_slot);
      field_cmp("gain_out", e.gain, a.gain);
      field_cmp("saturated", e.saturated, a.saturated);
      field_cmp("last_pole", e.last_pole, a.last_pole);
      n_checked++;
      if (e.saturated) n_sat++;
      if (e.last_pole) n_last++;
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [31:0] in_pole_re = 0;
  logic signed [31:0] in_pole_im = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] out_upper_re, out_upper_im, out_lower_re, out_lower_im;
  logic [3:0] out_upper_slot;
  logic [4:0] out_lower_slot;
  logic signed [31:0] out_gain_out;
  logic out_saturated, out_last_pole;
  logic psel = 0;
  logic penable = 0;
  logic pwrite = 0;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;

  pole_pair_board board;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 0;
  int hold_left = 0;
  int n_sent = 0;

  bandpass_pole_transform dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pole_re(in_pole_re), .in_pole_im(in_pole_im),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_upper_re(out_upper_re), .out_upper_im(out_upper_im),
    .out_lower_re(out_lower_re), .out_lower_im(out_lower_im),
    .out_upper_slot(out_upper_slot), .out_lower_slot(out_lower_slot),
    .out_gain_out(out_gain_out), .out_saturated(out_saturated),
    .out_last_pole(out_last_pole),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #25ms;
    $display("Regression FAIL");
    $finish;
  end

  // Check accepted pole pairs, then pick the next stall value
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_pair({out_upper_re, out_upper_im, out_lower_re, out_lower_im,
                        out_upper_slot, out_lower_slot, out_gain_out,
                        out_saturated, out_last_pole});
    if (hold_req) begin
      hold_req <= 0;
      hold_left = 3000;
    end
    if (!rst_n) begin
      out_stall <= 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_pole(logic signed [31:0] re, logic signed [31:0] im);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_pole_re <= re;
    in_pole_im <= im;
    do @(posedge clk); while (in_stall);
    board.note_pole(re, im);
    n_sent++;
  endtask

  // Drop valid and wait until every pending pole pair is back
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    board.write_reg(idx, val);
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_edge();
    case ($urandom_range(9))
      0: return 0;
      1: return 32'h7FFFFFFF;
      2, 3: return $urandom;
      default: return $urandom_range(32'h000A0000, 32'h00001000);
    endcase
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2, 3, 4: return $urandom;
      default: return $signed($urandom_range(32'h00080000)) - 32'sh00040000;
    endcase
  endfunction

  // Set a random configuration, always idle when called
  task automatic random_config();
    reg_write(bpt_pkg::REG_LOW_EDGE, rand_edge());
    reg_write(bpt_pkg::REG_HIGH_EDGE, rand_edge());
    reg_write(bpt_pkg::REG_PROTO_GAIN, ($urandom_range(3) == 0) ? $urandom
                                         : $urandom_range(32'h00040000));
    reg_write(bpt_pkg::REG_ORDER, ($urandom_range(4) == 0) ? $urandom
                                    : $urandom_range(16, 1));
  endtask

  initial begin
    int ph;
    board = new();
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: field extremes at reset settings
    send_pole(0, 0);
    send_pole(32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_pole(32'sh80000000, 32'sh80000000);
    send_pole(32'sh7FFFFFFF, 32'sh80000000);
    send_pole(-32'sd65536, 0);
    send_pole(-32'sd45000, 32'sd45000);
    send_pole(-32'sd45000, -32'sd45000);
    drain();
    // Order zero acts as one; order too large clamps
    reg_write(bpt_pkg::REG_ORDER, 0);
    send_pole(-32'sd65536, 32'sd100);
    send_pole(-32'sd30000, 32'sd60000);
    drain();
    reg_write(bpt_pkg::REG_ORDER, 31);
    reg_write(bpt_pkg::REG_PROTO_GAIN, 32'h80000000);
    repeat (3) send_pole(-32'sd40000, 32'sd50000);
    drain();
    // Order lowered mid-design ends the design at once
    reg_write(bpt_pkg::REG_ORDER, 2);
    send_pole(-32'sd40000, -32'sd50000);
    drain();
    reg_write(bpt_pkg::REG_ORDER, 4);
    repeat (3) send_pole(-32'sd20000, 32'sd70000);
    drain();
    reg_write(bpt_pkg::REG_ORDER, 16);
    send_pole(-32'sd20000, 0);
    drain();
    // Reversed edges and extreme edges
    reg_write(bpt_pkg::REG_ORDER, 3);
    reg_write(bpt_pkg::REG_LOW_EDGE, 32'h7FFFFFFF);
    reg_write(bpt_pkg::REG_HIGH_EDGE, 32'h00010000);
    reg_write(bpt_pkg::REG_PROTO_GAIN, 32'h7FFFFFFF);
    send_pole(-32'sd65536, 32'sd1);
    send_pole(32'sh7FFFFFFF, 0);
    drain();
    reg_write(bpt_pkg::REG_LOW_EDGE, 0);
    reg_write(bpt_pkg::REG_HIGH_EDGE, 0);
    send_pole(32'sh80000000, 32'sh7FFFFFFF);
    drain();

    // Random phases, cycling through the idling modes
    for (ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 60; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      random_config();
      // Long receiver hold-off with the sender still offering
      if (ph == 5) hold_req <= 1;
      repeat (104) send_pole(rand_value(), rand_value());
      drain();
    end

    repeat (200) @(posedge clk);
    $display("Mapped %0d poles over 12 random settings and directed corner cases;",
             n_sent);
    $display("%0d pairs checked, %0d saturated, %0d design ends.",
             board.n_checked, board.n_sat, board.n_last);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/bpt_pkg.sv
rtl/core/bpt_isqrt.sv
rtl/core/bpt_datapath.sv
rtl/core/bpt_ctrl.sv
rtl/core/bandpass_pole_transform.sv
rtl/core/bpt_checker.sv
tb/tb_bandpass_pole_transform.sv
